// ===== rtl/core/bpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared types and constants of the bitmap pixel to BGRA converter.
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int unsigned CODE_W    = 32;  // pixel code, palette entry, masks
  localparam int unsigned PIX_IDX_W = 8;   // palette index field
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned QUO_W     = 8;   // scaled channel fits in one byte
  localparam int unsigned NUM_W     = CODE_W + QUO_W;  // field * 255
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Channel slots in the per-channel vectors
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  localparam logic CMD_CONVERT   = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PALETTE  = 2'd0,
    MODE_MASK16   = 2'd1,
    MODE_DIRECT24 = 2'd2,
    MODE_MASK32   = 2'd3
  } pixel_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_MODE = 2'd0,
    REG_RED_MASK   = 2'd1,
    REG_GREEN_MASK = 2'd2,
    REG_BLUE_MASK  = 2'd3
  } cfg_reg_e;

  localparam logic [CODE_W-1:0] RED_MASK_RST   = 32'h0000_7c00;
  localparam logic [CODE_W-1:0] GREEN_MASK_RST = 32'h0000_03e0;
  localparam logic [CODE_W-1:0] BLUE_MASK_RST  = 32'h0000_001f;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'hff;

  typedef logic [NUM_CH-1:0][CODE_W-1:0] mask_vec_t;

  // Payload of one divider pipeline stage
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;       // partial remainders
    logic [NUM_CH-1:0][QUO_W-1:0] quo;       // quotient bits found so far
    logic [NUM_CH-1:0]            zero_mask; // channel forced to zero
    logic                         sel_pass;  // palette or direct result
    logic [CODE_W-1:0]            pass_bgra; // {alpha, red, green, blue}
  } div_t;

endpackage

// ===== rtl/core/bpb_ifs.sv =====
// ----------------------------------------------------------------------------
// bpb_ifs
// Valid/ready stream channels: pixel commands in, BGRA pixels out.
// ----------------------------------------------------------------------------
interface bpb_pix_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [bpb_pkg::CODE_W-1:0]          pixel_code;
  logic [bpb_pkg::PIX_IDX_W-1:0]       palette_index;
  logic [bpb_pkg::CODE_W-1:0]          palette_entry;

  modport source (
    output valid, command, pixel_code, palette_index, palette_entry,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_code, palette_index, palette_entry,
    output ready
  );
endinterface

interface bpb_bgra_if;
  logic                        valid;
  logic                        ready;
  logic [bpb_pkg::BYTE_W-1:0]  blue_out;
  logic [bpb_pkg::BYTE_W-1:0]  green_out;
  logic [bpb_pkg::BYTE_W-1:0]  red_out;
  logic [bpb_pkg::BYTE_W-1:0]  alpha_out;

  modport source (
    output valid, blue_out, green_out, red_out, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, blue_out, green_out, red_out, alpha_out,
    output ready
  );
endinterface

// ===== rtl/core/bpb_front.sv =====
// ----------------------------------------------------------------------------
// bpb_front
// Beat intake, palette memory and the first two pipeline stages: channel
// masking, then numerator forming (field * 255) and pass-through bytes.
// ----------------------------------------------------------------------------
module bpb_front #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpb_pix_if.sink             pix_i,
  input  bpb_pkg::pixel_mode_e mode_i,
  input  bpb_pkg::mask_vec_t  mask_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bpb_pkg::div_t       data_o
);
  import bpb_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

  logic [CODE_W-1:0] pal_mem [PALETTE_DEPTH];

  logic              en1, en2, accept, v1_d;
  logic              v1_q, v2_q;
  logic              wr_in_range, rd_in_range;
  logic [CODE_W-1:0] code_used;
  logic [NUM_CH-1:0][CODE_W-1:0] field_d, field_q;
  logic [CODE_W-1:0] rd_q;
  logic              oob_q;
  logic [3*BYTE_W-1:0] direct_q;
  div_t              data_d, data_q;

  assign en2    = !v2_q || ready_i;
  assign en1    = !v1_q || en2;
  assign accept = pix_i.valid && en1;
  assign pix_i.ready = en1;
  assign v1_d   = accept && (pix_i.command == CMD_CONVERT);

  assign wr_in_range = {1'b0, pix_i.palette_index} < (PIX_IDX_W+1)'(PALETTE_DEPTH);
  assign rd_in_range = {1'b0, pix_i.pixel_code[PIX_IDX_W-1:0]}
                       < (PIX_IDX_W+1)'(PALETTE_DEPTH);

  // 16-bit mode ignores the upper half of the code
  always_comb begin
    code_used = pix_i.pixel_code;
    if (mode_i == MODE_MASK16) begin
      code_used = {{(CODE_W-16){1'b0}}, pix_i.pixel_code[15:0]};
    end
    for (int c = 0; c < NUM_CH; c++) begin
      field_d[c] = code_used & mask_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (pix_i.command == CMD_PAL_WRITE) && wr_in_range) begin
      pal_mem[pix_i.palette_index[IDX_W-1:0]] <= pix_i.palette_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      rd_q <= pal_mem[pix_i.pixel_code[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      field_q  <= field_d;
      oob_q    <= !rd_in_range;
      direct_q <= pix_i.pixel_code[3*BYTE_W-1:0];
    end
  end

  // Scaling by 255/(mask>>s) equals scaling the unshifted field by 255/mask
  always_comb begin
    data_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      data_d.rem[c] = {field_q[c], {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, field_q[c]};
      data_d.zero_mask[c] = (mask_i[c] == '0);
    end
    case (mode_i)
      MODE_PALETTE: begin
        data_d.sel_pass  = 1'b1;
        data_d.pass_bgra = oob_q ? '0 : rd_q;
      end
      MODE_DIRECT24: begin
        data_d.sel_pass  = 1'b1;
        data_d.pass_bgra = {ALPHA_OPAQUE, direct_q};
      end
      default: begin
        data_d.sel_pass  = 1'b0;
        data_d.pass_bgra = {ALPHA_OPAQUE, direct_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= v1_d;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  // A palette write never turns into a pipeline item
  a_pal_write_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready && (pix_i.command == CMD_PAL_WRITE) |=> !v1_q)
    else $error("palette write produced a pipeline item");
`endif

endmodule

// ===== rtl/core/bpb_div_step.sv =====
// ----------------------------------------------------------------------------
// bpb_div_step
// One restoring-division stage: resolves quotient bit BIT for all three
// channels against the channel mask shifted left by BIT.
// ----------------------------------------------------------------------------
module bpb_div_step #(
  parameter int unsigned BIT = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpb_pkg::mask_vec_t mask_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  bpb_pkg::div_t      data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output bpb_pkg::div_t      data_o
);
  import bpb_pkg::*;

  logic [NUM_CH-1:0][NUM_W-1:0] trial;
  logic [NUM_CH-1:0]            ge;
  div_t                         data_d, data_q;
  logic                         valid_q, en;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    data_d = data_i;
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = NUM_W'(mask_i[c]) << BIT;
      ge[c]    = data_i.rem[c] >= trial[c];
      if (ge[c]) begin
        data_d.rem[c] = data_i.rem[c] - trial[c];
      end
      data_d.quo[c][BIT] = ge[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(data_o))
    else $error("divider stage lost or changed a stalled item");
`endif

endmodule

// ===== rtl/core/bitmap_pixel_to_bgra.sv =====
// ----------------------------------------------------------------------------
// bitmap_pixel_to_bgra
// Converts raw bitmap pixel codes to blue, green, red and alpha bytes.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries command beats. A convert beat turns pixel_code into one
//   bgra_o beat; a palette write beat stores palette_entry at palette_index
//   and yields no output beat. Beats come out in the order they went in.
//   Config (mode, red/green/blue masks) is to be written by the user through
//   cfg_we_i/idx/data only while the pipeline is empty; the block has no check.
//   A convert beat passes the intake/mask stage, the numerator stage, eight
//   divider stages and the output register on its way to bgra_o.
//   Throughput: one beat per clock while bgra_o is not stalled, set by the
//   divider resolving one quotient bit per stage for all three channels.
//   A palette write is visible to a convert beat accepted on the next edge.
//   Reset clears all valid bits and restores the config registers (16-bit
//   mode, 5-5-5 masks); palette contents are undefined until written.
//   When the receiver stalls, each stage holds its item and bubbles are
//   squeezed out, so pix_i keeps accepting until every stage is full.
// ----------------------------------------------------------------------------
module bitmap_pixel_to_bgra #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bpb_pix_if.sink                            pix_i,
  bpb_bgra_if.source                         bgra_o,
  input  logic                               cfg_we_i,
  input  logic [bpb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpb_pkg::CODE_W-1:0]         cfg_data_i
);
  import bpb_pkg::*;

  localparam int unsigned NUM_STEPS = QUO_W;

  // Configuration registers
  pixel_mode_e       mode_q;
  logic [CODE_W-1:0] red_mask_q, green_mask_q, blue_mask_q;
  mask_vec_t         masks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_MASK16;
      red_mask_q   <= RED_MASK_RST;
      green_mask_q <= GREEN_MASK_RST;
      blue_mask_q  <= BLUE_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PIXEL_MODE: mode_q       <= pixel_mode_e'(cfg_data_i[1:0]);
        REG_RED_MASK:   red_mask_q   <= cfg_data_i;
        REG_GREEN_MASK: green_mask_q <= cfg_data_i;
        REG_BLUE_MASK:  blue_mask_q  <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    masks          = '0;
    masks[CH_BLUE]  = blue_mask_q;
    masks[CH_GREEN] = green_mask_q;
    masks[CH_RED]   = red_mask_q;
  end

  // Pipeline chain: slot 0 is the front's output, slot k the k-th divider step
  logic [NUM_STEPS:0] stg_v;
  logic [NUM_STEPS:0] stg_rdy;
  div_t               stg_d [NUM_STEPS+1];

  bpb_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .mode_i  (mode_q),
    .mask_i  (masks),
    .valid_o (stg_v[0]),
    .ready_i (stg_rdy[0]),
    .data_o  (stg_d[0])
  );

  // Resolve quotient bits from the top one down
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_div
    bpb_div_step #(
      .BIT(NUM_STEPS - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mask_i  (masks),
      .valid_i (stg_v[i]),
      .ready_o (stg_rdy[i]),
      .data_i  (stg_d[i]),
      .valid_o (stg_v[i+1]),
      .ready_i (stg_rdy[i+1]),
      .data_o  (stg_d[i+1])
    );
  end

  // Output register
  logic              out_v_q, en_out;
  logic [CODE_W-1:0] bgra_d, bgra_q;
  div_t              last;

  assign en_out             = !out_v_q || bgra_o.ready;
  assign stg_rdy[NUM_STEPS] = en_out;
  assign last               = stg_d[NUM_STEPS];

  // Pick the palette/direct bytes or the scaled channels; zero masks give 0
  always_comb begin
    if (last.sel_pass) begin
      bgra_d = last.pass_bgra;
    end else begin
      bgra_d = {ALPHA_OPAQUE,
                last.zero_mask[CH_RED]   ? '0 : last.quo[CH_RED],
                last.zero_mask[CH_GREEN] ? '0 : last.quo[CH_GREEN],
                last.zero_mask[CH_BLUE]  ? '0 : last.quo[CH_BLUE]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      bgra_q <= bgra_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= stg_v[NUM_STEPS];
    end
  end

  assign bgra_o.valid     = out_v_q;
  assign bgra_o.blue_out  = bgra_q[BYTE_W-1:0];
  assign bgra_o.green_out = bgra_q[2*BYTE_W-1:BYTE_W];
  assign bgra_o.red_out   = bgra_q[3*BYTE_W-1:2*BYTE_W];
  assign bgra_o.alpha_out = bgra_q[4*BYTE_W-1:3*BYTE_W];

`ifndef SYNTHESIS
  // Intake only backs up once the whole pipeline is full and stalled
  a_backpressure_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> out_v_q && !bgra_o.ready && (&stg_v))
    else $error("intake stalled while the pipeline had room");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !bgra_o.valid)
    else $error("output valid right after reset");
`endif

endmodule
